// ----- hdl/set_assoc_lru_cache_model_core_defines.svh -----
// Assertion macros shared by the cache model RTL.
// Included by salc_front and salc_back; needs nothing else.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define SALC_ASSERT_NOW(lbl, clk_s, rst_s, trig, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |-> (cond)) \
    else $error("salc: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define SALC_ASSERT_NEXT(lbl, clk_s, rst_s, trig, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (trig) |=> (cond)) \
    else $error("salc: next-cycle check failed");

`endif

// ----- hdl/salc_pkg.sv -----
// Shared types, codes and constants of the set-associative cache model.
// No dependencies; imported by the top level, salc_front and salc_back.
package salc_pkg;

  localparam int AGE_W      = 3;
  localparam int CNT_W      = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int KIND_W     = 2;
  localparam int OUTCOME_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int SBITS_W    = 4;
  localparam int BBITS_W    = 6;
  localparam int QDEPTH     = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_MODIFY = 2'd2
  } kind_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS        = 2'd2
  } cfg_idx_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic valid;
    logic modify;
  } q_head_t;

  // Back-end status returned to the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

  function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
    return (a == AGE_MAX) ? a : a + 1'b1;
  endfunction

endpackage

// ----- hdl/set_assoc_lru_cache_model_core.sv -----
// Top level of the tag-only set-associative LRU cache model.
// Depends on salc_pkg, salc_front, salc_back (and salc_ram below it).
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    kind, address
//   result    out_valid / out_ready  outcome, way_touched, hit_total, miss_total,
//                                    eviction_total, last_of_run
//   config    wr_en                  wr_index, wr_data
//
// In the back end, ST_IDLE reads the set row of a load or store from the
// row RAM and ST_EXEC updates and writes it back. A modify passes through
// ST_REREAD and ST_EXEC again, since its store part reads the row again
// after the load part wrote it. After reset a clearing pass writes every
// row with in_ready low. A two-entry queue lets requests arrive while the back
// end works, and a held result stalls only the back end until it is taken.
module set_assoc_lru_cache_model_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [salc_pkg::KIND_W-1:0]       kind,
  input  logic [ADDR_WIDTH-1:0]             address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [salc_pkg::OUTCOME_W-1:0]    outcome,
  output logic [salc_pkg::WAY_OUT_W-1:0]    way_touched,
  output logic [salc_pkg::CNT_W-1:0]        hit_total,
  output logic [salc_pkg::CNT_W-1:0]        miss_total,
  output logic [salc_pkg::CNT_W-1:0]        eviction_total,
  output logic                              last_of_run
);
  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WC_W  = $clog2(MAX_WAYS + 1);

  logic [2:0]            set_index_bits;
  logic [5:0]            block_offset_bits;
  logic [3:0]            ways_in_use;
  logic [SBITS_W-1:0]    sbits_eff;
  logic [WC_W-1:0]       ways_eff;

  q_head_t               q;
  bk_stat_t              stat;
  logic [SET_W-1:0]      q_set;
  logic [ADDR_WIDTH-1:0] q_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= '0;
      block_offset_bits <= '0;
      ways_in_use       <= 4'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SET_BITS:    set_index_bits    <= wr_data[2:0];
        CFG_OFFSET_BITS: block_offset_bits <= wr_data;
        CFG_WAYS:        ways_in_use       <= wr_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are clamped to what the storage holds.
  always_comb begin
    if (int'(set_index_bits) > MAX_SET_BITS) begin
      sbits_eff = SBITS_W'(MAX_SET_BITS);
    end else begin
      sbits_eff = SBITS_W'(set_index_bits);
    end
    if (ways_in_use == '0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_in_use);
    end
  end

  salc_front #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .sbits   (sbits_eff),
    .bbits   (block_offset_bits),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind    (kind),
    .address (address),
    .stat    (stat),
    .q       (q),
    .q_set   (q_set),
    .q_tag   (q_tag)
  );

  salc_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ways          (ways_eff),
    .q             (q),
    .q_set         (q_set),
    .q_tag         (q_tag),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .outcome       (outcome),
    .way_touched   (way_touched),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .eviction_total(eviction_total),
    .last_of_run   (last_of_run)
  );

endmodule

// ----- hdl/salc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/salc_front.sv -----
// Front end: accepts requests, splits the address into set and tag,
// and queues them for the back end. Depends on salc_pkg and the defines header.
`include "set_assoc_lru_cache_model_core_defines.svh"

module salc_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [salc_pkg::SBITS_W-1:0]           sbits,
  input  logic [salc_pkg::BBITS_W-1:0]           bbits,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [salc_pkg::KIND_W-1:0]            kind,
  input  logic [ADDR_WIDTH-1:0]                  address,
  input  salc_pkg::bk_stat_t                     stat,
  output salc_pkg::q_head_t                      q,
  output logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] q_set,
  output logic [ADDR_WIDTH-1:0]                  q_tag
);
  import salc_pkg::*;

  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W  = $clog2(QDEPTH + 1);

  logic [SET_W-1:0]      set_mem [QDEPTH];
  logic [ADDR_WIDTH-1:0] tag_mem [QDEPTH];
  logic [QDEPTH-1:0]     mod_mem;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [QC_W-1:0]       count;

  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_W-1:0]      smask;
  logic [SET_W-1:0]      set_calc;
  logic [ADDR_WIDTH-1:0] tag_calc;
  logic                  push;
  logic                  pop;

  always_comb begin
    shifted = address >> bbits;
    for (int i = 0; i < SET_W; i++) begin
      smask[i] = (SBITS_W'(i) < sbits);
    end
    set_calc = shifted[SET_W-1:0] & smask;
    // A shift amount at or beyond the address width leaves an empty tag.
    tag_calc = address >> (7'(bbits) + 7'(sbits));
  end

  assign in_ready = (count < QC_W'(QDEPTH)) && !stat.clearing;
  assign push     = in_valid && in_ready;
  assign pop      = stat.pop;

  assign q.valid  = (count != '0);
  assign q.modify = mod_mem[rd_ptr];
  assign q_set    = set_mem[rd_ptr];
  assign q_tag    = tag_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      set_mem[wr_ptr] <= set_calc;
      tag_mem[wr_ptr] <= tag_calc;
      mod_mem[wr_ptr] <= (kind == KIND_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SALC_ASSERT_NOW(a_fq_bound, clk, rst, 1'b1, count <= QC_W'(QDEPTH))
  `SALC_ASSERT_NOW(a_fq_hold, clk, rst, stat.clearing, !in_ready)
  `SALC_ASSERT_NOW(a_fq_pop_nonempty, clk, rst, pop, count != '0)

endmodule

// ----- hdl/salc_back.sv -----
// Back end: reads a set row, resolves hit, fill or eviction, updates LRU
// ages and totals, and holds the result. Depends on salc_pkg, salc_ram, defines.
`include "set_assoc_lru_cache_model_core_defines.svh"

module salc_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [$clog2(MAX_WAYS + 1)-1:0]        ways,
  input  salc_pkg::q_head_t                      q,
  input  logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] q_set,
  input  logic [ADDR_WIDTH-1:0]                  q_tag,
  output salc_pkg::bk_stat_t                     stat,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [salc_pkg::OUTCOME_W-1:0]         outcome,
  output logic [salc_pkg::WAY_OUT_W-1:0]         way_touched,
  output logic [salc_pkg::CNT_W-1:0]             hit_total,
  output logic [salc_pkg::CNT_W-1:0]             miss_total,
  output logic [salc_pkg::CNT_W-1:0]             eviction_total,
  output logic                                   last_of_run
);
  import salc_pkg::*;

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 2 ** MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W     = $clog2(MAX_WAYS + 1);
  localparam int LINE_W   = 1 + AGE_W + ADDR_WIDTH;
  localparam int ROW_W    = MAX_WAYS * LINE_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_REREAD} state_t;

  state_t                state;
  logic [SET_W-1:0]      clr_idx;
  logic [SET_W-1:0]      cur_set;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic                  cur_mod;
  logic                  second;

  logic                  ram_we;
  logic [SET_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [SET_W-1:0]      ram_raddr;
  logic [ROW_W-1:0]      rdata;

  logic [MAX_WAYS-1:0]   vld;
  logic [MAX_WAYS-1:0]   in_use;
  logic [MAX_WAYS-1:0]   hit_vec;
  logic [MAX_WAYS-1:0]   free_vec;
  logic [AGE_W-1:0]      age [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tagv [MAX_WAYS];
  logic                  hit;
  logic                  free_found;
  logic [WAY_W-1:0]      hitw;
  logic [WAY_W-1:0]      freew;
  logic [WAY_W-1:0]      evw;
  logic [AGE_W-1:0]      best;
  logic [AGE_W-1:0]      ha;
  logic [WAY_W-1:0]      way_sel;
  outcome_t              outcome_sel;
  logic [ROW_W-1:0]      new_row;
  logic                  emit;

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // Hit search, free-way search and LRU victim choice over the row.
  always_comb begin
    logic                  nv;
    logic [AGE_W-1:0]      na;
    logic [ADDR_WIDTH-1:0] nt;

    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w]      = rdata[w*LINE_W + LINE_W - 1];
      age[w]      = rdata[w*LINE_W + ADDR_WIDTH +: AGE_W];
      tagv[w]     = rdata[w*LINE_W +: ADDR_WIDTH];
      in_use[w]   = (WC_W'(w) < ways);
      hit_vec[w]  = in_use[w] && vld[w] && (tagv[w] == cur_tag);
      free_vec[w] = in_use[w] && !vld[w];
    end
    hit        = |hit_vec;
    free_found = |free_vec;

    hitw  = '0;
    freew = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hitw = WAY_W'(w);
      end
      if (free_vec[w]) begin
        freew = WAY_W'(w);
      end
    end

    // Among equally old lines the highest way is the victim.
    best = '0;
    evw  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && age[w] >= best) begin
        best = age[w];
        evw  = WAY_W'(w);
      end
    end

    ha = age[hitw];
    if (hit) begin
      way_sel     = hitw;
      outcome_sel = OUT_HIT;
    end else if (free_found) begin
      way_sel     = freew;
      outcome_sel = OUT_FILL;
    end else begin
      way_sel     = evw;
      outcome_sel = OUT_EVICT;
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      nv = vld[w];
      na = age[w];
      nt = tagv[w];
      if (hit) begin
        if (WAY_W'(w) == hitw) begin
          na = '0;
        end else if (in_use[w] && vld[w] && age[w] < ha) begin
          na = age_up(age[w]);
        end
      end else begin
        if (WAY_W'(w) == way_sel) begin
          nv = 1'b1;
          na = '0;
          nt = cur_tag;
        end else if (in_use[w] && vld[w]) begin
          na = age_up(age[w]);
        end
      end
      new_row[w*LINE_W +: LINE_W] = {nv, na, nt};
    end
  end

  assign emit          = (state == ST_EXEC) && (!out_valid || out_ready);
  assign stat.pop      = (state == ST_IDLE) && q.valid;
  assign stat.clearing = (state == ST_CLEAR);

  assign ram_raddr = (state == ST_IDLE) ? q_set : cur_set;
  assign ram_we    = (state == ST_CLEAR) || emit;
  assign ram_waddr = (state == ST_CLEAR) ? clr_idx : cur_set;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      second         <= 1'b0;
      out_valid      <= 1'b0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q.valid) begin
            cur_set <= q_set;
            cur_tag <= q_tag;
            cur_mod <= q.modify;
            second  <= 1'b0;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (emit) begin
            outcome     <= outcome_sel;
            way_touched <= WAY_OUT_W'(way_sel);
            last_of_run <= !(cur_mod && !second);
            if (hit) begin
              hit_total <= hit_total + 1'b1;
            end else begin
              miss_total <= miss_total + 1'b1;
            end
            if (!hit && !free_found) begin
              eviction_total <= eviction_total + 1'b1;
            end
            if (cur_mod && !second) begin
              second <= 1'b1;
              state  <= ST_REREAD;
            end else begin
              state  <= ST_IDLE;
            end
          end
        end
        ST_REREAD: begin
          state <= ST_EXEC;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SALC_ASSERT_NOW(a_bk_way_range, clk, rst, state == ST_EXEC, WC_W'(way_sel) < ways)
  `SALC_ASSERT_NOW(a_bk_store_part_hits, clk, rst, state == ST_EXEC && second, hit)
  `SALC_ASSERT_NEXT(a_bk_one_count, clk, rst, emit, hit_total + miss_total == $past(hit_total) + $past(miss_total) + 1)

endmodule

// ----- test/set_assoc_lru_cache_model_core_tb.sv -----
// Self-checking testbench for set_assoc_lru_cache_model_core, the tag-only LRU cache model.
// Depends on salc_pkg and the RTL; a scoreboard class predicts every result from the requests.
module set_assoc_lru_cache_model_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int MAX_SET_BITS    = 6;
  localparam int MAX_WAYS        = 8;
  localparam int ADDR_WIDTH      = 64;
  localparam int NUM_LINES       = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int DRAIN_SLACK     = 8;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AT         = 400;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int MAX_PRINTED     = 50;

  // Codes the port allows but the package leaves unnamed.
  localparam logic [KIND_W-1:0]    KIND_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    outcome_t         outcome;
    logic [2:0]       way;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
    logic             last;
  } cache_result_t;

  class cache_scoreboard;
    logic [2:0]       set_bits_cfg;
    logic [5:0]       offset_bits_cfg;
    logic [3:0]       ways_cfg;
    bit               line_valid [NUM_LINES];
    logic [63:0]      line_tag   [NUM_LINES];
    logic [2:0]       line_age   [NUM_LINES];
    logic [CNT_W-1:0] hits_tally;
    logic [CNT_W-1:0] misses_tally;
    logic [CNT_W-1:0] evict_count;
    cache_result_t    expected_results [$];
    int               errors;
    int               checked;

    function new();
      set_bits_cfg    = 3'd0;
      offset_bits_cfg = 6'd0;
      ways_cfg        = 4'd1;
      for (int i = 0; i < NUM_LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = 64'd0;
        line_age[i]   = 3'd0;
      end
      hits_tally   = '0;
      misses_tally = '0;
      evict_count  = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      unique case (idx)
        CFG_SET_BITS:    set_bits_cfg    = data[2:0];
        CFG_OFFSET_BITS: offset_bits_cfg = data[5:0];
        CFG_WAYS:        ways_cfg        = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] bump_age(logic [2:0] a);
      return (a == 3'd7) ? a : a + 3'd1;
    endfunction

    // One lookup and update of the selected set; pushes the expected result.
    function void access_line(logic [63:0] addr, bit last_part);
      int            sbits;
      int            bbits;
      int            ways;
      int            set_idx;
      int            base;
      int            hit_way;
      int            way;
      bit            hit;
      bit            free_found;
      logic [2:0]    hit_age;
      logic [2:0]    oldest;
      logic [63:0]   tag;
      cache_result_t r;
      sbits   = (set_bits_cfg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_cfg);
      bbits   = int'(offset_bits_cfg);
      ways    = (ways_cfg == 0) ? 1 : ((ways_cfg > MAX_WAYS) ? MAX_WAYS : int'(ways_cfg));
      set_idx = int'((addr >> bbits) & ((64'd1 << sbits) - 64'd1));
      tag     = (bbits + sbits >= 64) ? 64'd0 : (addr >> (bbits + sbits));
      base    = set_idx * MAX_WAYS;
      hit     = 1'b0;
      hit_way = 0;
      way     = 0;
      for (int w = 0; w < ways; w++) begin
        if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
          hit     = 1'b1;
          hit_way = w;
        end
      end
      if (hit) begin
        // True LRU: only lines younger than the hit line move back.
        hit_age = line_age[base + hit_way];
        for (int w = 0; w < ways; w++) begin
          if (w != hit_way && line_valid[base + w] && line_age[base + w] < hit_age)
            line_age[base + w] = bump_age(line_age[base + w]);
        end
        line_age[base + hit_way] = 3'd0;
        hits_tally++;
        way       = hit_way;
        r.outcome = OUT_HIT;
      end else begin
        misses_tally++;
        free_found = 1'b0;
        for (int w = 0; w < ways; w++) begin
          if (!free_found && !line_valid[base + w]) begin
            free_found = 1'b1;
            way        = w;
          end
        end
        if (free_found) begin
          r.outcome = OUT_FILL;
        end else begin
          // The highest way wins a tie on age.
          oldest = 3'd0;
          for (int w = 0; w < ways; w++) begin
            if (line_age[base + w] >= oldest) begin
              oldest = line_age[base + w];
              way    = w;
            end
          end
          evict_count++;
          r.outcome = OUT_EVICT;
        end
        for (int w = 0; w < ways; w++) begin
          if (w != way && line_valid[base + w])
            line_age[base + w] = bump_age(line_age[base + w]);
        end
        line_valid[base + way] = 1'b1;
        line_tag[base + way]   = tag;
        line_age[base + way]   = 3'd0;
      end
      r.way       = way[2:0];
      r.hits      = hits_tally;
      r.misses    = misses_tally;
      r.evictions = evict_count;
      r.last      = last_part;
      expected_results.push_back(r);
    endfunction

    function void note_request(logic [KIND_W-1:0] k, logic [63:0] addr);
      if (k == KIND_MODIFY) begin
        access_line(addr, 1'b0);
        access_line(addr, 1'b1);
      end else begin
        access_line(addr, 1'b1);
      end
    endfunction

    task report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
      if (errors < MAX_PRINTED)
        $display("result %0d: %s mismatch, expected 0x%0h, got 0x%0h",
                 checked, what, exp_v, got_v);
      errors++;
    endtask

    task check_result(logic [OUTCOME_W-1:0] outc, logic [WAY_OUT_W-1:0] way,
                      logic [CNT_W-1:0] hits, logic [CNT_W-1:0] misses,
                      logic [CNT_W-1:0] evictions, logic last);
      cache_result_t e;
      checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, {62'd0, outc});
      end else begin
        e = expected_results.pop_front();
        if (outc !== e.outcome)      report_mismatch("outcome", e.outcome, outc);
        if (way !== e.way)           report_mismatch("way_touched", e.way, way);
        if (hits !== e.hits)         report_mismatch("hit_total", e.hits, hits);
        if (misses !== e.misses)     report_mismatch("miss_total", e.misses, misses);
        if (evictions !== e.evictions)
          report_mismatch("eviction_total", e.evictions, evictions);
        if (last !== e.last)         report_mismatch("last_of_run", e.last, last);
      end
    endtask
  endclass

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    wr_en          = 1'b0;
  logic [CFG_IDX_W-1:0]    wr_index       = '0;
  logic [CFG_DATA_W-1:0]   wr_data        = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic [KIND_W-1:0]       kind           = '0;
  logic [ADDR_WIDTH-1:0]   address        = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic [OUTCOME_W-1:0]    outcome;
  logic [WAY_OUT_W-1:0]    way_touched;
  logic [CNT_W-1:0]        hit_total;
  logic [CNT_W-1:0]        miss_total;
  logic [CNT_W-1:0]        eviction_total;
  logic                    last_of_run;

  cache_scoreboard sb = new();

  int requests_taken = 0;
  int results_taken  = 0;
  int quiet_cycles   = 0;
  int settings_used  = 0;
  bit sink_idles     = 1'b0;

  set_assoc_lru_cache_model_core #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .address       (address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .outcome       (outcome),
    .way_touched   (way_touched),
    .hit_total     (hit_total),
    .miss_total    (miss_total),
    .eviction_total(eviction_total),
    .last_of_run   (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything seen at an edge is the value from before it, since all drivers use nonblocking.
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) sb.write_config(wr_index, wr_data);
      if (in_valid && in_ready) begin
        sb.note_request(kind, address);
        requests_taken <= requests_taken + 1;
      end
      if (out_valid && out_ready) begin
        sb.check_result(outcome, way_touched, hit_total, miss_total, eviction_total,
                        last_of_run);
        results_taken <= results_taken + 1;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // Result side: random stall bursts, plus one long hold that backs the block up.
  initial begin : result_sink
    int  hold_left;
    bit  long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && requests_taken >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        out_ready      <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Holds the request until it is taken; the caller decides whether valid drops afterwards.
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [63:0] a);
    in_valid <= 1'b1;
    kind     <= k;
    address  <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  // Unused high bits of the write data carry random junk, which the block must ignore.
  task automatic apply_settings(input int sbits, input int bbits, input int ways);
    wait_drained();
    write_register(CFG_SET_BITS, {3'($urandom()), 3'(sbits)});
    write_register(CFG_OFFSET_BITS, 6'(bbits));
    write_register(CFG_WAYS, {2'($urandom()), 4'(ways)});
    wr_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 15);
    if (r < 6) return KIND_LOAD;
    if (r < 11) return KIND_STORE;
    if (r < 15) return KIND_MODIFY;
    return KIND_SPARE;
  endfunction

  // Mostly addresses built from a few tags in a few sets so lines are reused and evicted;
  // now and then a fully random address.
  function automatic logic [63:0] make_address(int sbits, int bbits, int ways,
                                               logic [63:0] tag_base);
    logic [63:0] tag;
    logic [63:0] setv;
    logic [63:0] offs;
    logic [63:0] a;
    int          nsets;
    int          shift;
    nsets = 1 << sbits;
    shift = sbits + bbits;
    if ($urandom_range(0, 6) == 0) return {$urandom(), $urandom()};
    tag = tag_base + 64'($urandom_range(0, ways * 2));
    if ($urandom_range(0, 3) == 0) setv = 64'($urandom_range(0, nsets - 1));
    else setv = 64'($urandom_range(0, ((nsets < 4) ? nsets : 4) - 1));
    offs = {$urandom(), $urandom()} & ((64'd1 << bbits) - 64'd1);
    a = (setv << bbits) | offs;
    if (shift < 64) a = a | (tag << shift);
    return a;
  endfunction

  initial begin : stimulus
    int          set_tab [PHASES];
    int          off_tab [PHASES];
    int          way_tab [PHASES];
    bit          sender_idles;
    logic [63:0] tag_base;
    int          sbits_eff;
    int          ways_eff;

    set_tab = '{0, 6, 7, 3, 0, 1, 2, 6, 4, 5, 2, 3};
    off_tab = '{0, 32, 63, 5, 0, 32, 6, 0, 12, 40, 3, 60};
    way_tab = '{1, 8, 15, 4, 0, 8, 3, 8, 5, 7, 2, 6};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Wait out the clearing pass after reset.
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // Reset settings: one way, one set, the whole address is the tag.
    send_request(KIND_LOAD, 64'd0);
    send_request(KIND_LOAD, 64'd0);
    send_request(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_MODIFY, 64'd5);
    send_request(KIND_SPARE, 64'd5);

    // Two ways, four sets, 16-byte blocks: fill, hit, LRU eviction and modify.
    apply_settings(2, 4, 2);
    write_register(CFG_SPARE_IDX, 6'h3F);
    wr_en <= 1'b0;
    @(posedge clk);
    send_request(KIND_LOAD, 64'h40);
    send_request(KIND_LOAD, 64'h80);
    send_request(KIND_LOAD, 64'h40);
    send_request(KIND_LOAD, 64'hC0);
    send_request(KIND_MODIFY, 64'h80);
    send_request(KIND_STORE, 64'h4F);
    send_request(KIND_LOAD, 64'h50);
    send_request(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_LOAD, 64'h8000_0000_0000_0000);
    send_request(KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);

    // Out-of-range set bits and ways, and an offset that pushes the tag off the address.
    apply_settings(7, 63, 15);
    send_request(KIND_LOAD, 64'd0);
    send_request(KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_LOAD, 64'h8000_0000_0000_0000);
    send_request(KIND_MODIFY, 64'd1);
    send_request(KIND_STORE, 64'h7FFF_FFFF_FFFF_FFFF);

    for (int p = 0; p < PHASES; p++) begin
      apply_settings(set_tab[p], off_tab[p], way_tab[p]);
      // The last phases run at full rate on both sides.
      sender_idles = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
      sink_idles   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
      tag_base     = {$urandom(), $urandom()};
      sbits_eff    = (set_tab[p] > MAX_SET_BITS) ? MAX_SET_BITS : set_tab[p];
      ways_eff     = (way_tab[p] == 0) ? 1 : ((way_tab[p] > MAX_WAYS) ? MAX_WAYS : way_tab[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (sender_idles && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 18));
        send_request(pick_kind(), make_address(sbits_eff, off_tab[p], ways_eff, tag_base));
      end
    end

    wait_drained();
    $display("ran %0d requests under %0d cache settings, %0d results checked",
             requests_taken, settings_used, results_taken);
    $display("final totals: %0d hits, %0d misses, %0d evictions",
             sb.hits_tally, sb.misses_tally, sb.evict_count);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/salc_pkg.sv
hdl/salc_ram.sv
hdl/salc_front.sv
hdl/salc_back.sv
hdl/set_assoc_lru_cache_model_core.sv
test/set_assoc_lru_cache_model_core_tb.sv
